### design/cbm_pkg.sv
package cbm_pkg;

  localparam logic [2:0] REQ_PRG_RD = 3'd0;
  localparam logic [2:0] REQ_PRG_WR = 3'd1;
  localparam logic [2:0] REQ_CHR_RD = 3'd2;
  localparam logic [2:0] REQ_CHR_WR = 3'd3;
  localparam logic [2:0] REQ_REINIT = 3'd4;

  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_ROM = 2'd1;
  localparam logic [1:0] TGT_CHR_ROM = 2'd2;
  localparam logic [1:0] TGT_CHR_RAM = 2'd3;

  localparam logic [7:0] MAP_SERIAL = 8'd1;
  localparam logic [7:0] MAP_PRG16  = 8'd2;
  localparam logic [7:0] MAP_CHR8   = 8'd3;
  localparam logic [7:0] MAP_PRG32  = 8'd7;

  localparam logic [1:0] CFG_MAPPER     = 2'd0;
  localparam logic [1:0] CFG_PRG_CHUNKS = 2'd1;
  localparam logic [1:0] CFG_CHR_CHUNKS = 2'd2;

  localparam logic [1:0] SER_CONTROL  = 2'd0;
  localparam logic [1:0] SER_CHR_LOW  = 2'd1;
  localparam logic [1:0] SER_CHR_HIGH = 2'd2;
  localparam logic [1:0] SER_PRG_BANK = 2'd3;

  localparam logic [4:0] CONTROL_RESET = 5'h0C;
  localparam logic [2:0] SERIAL_LAST   = 3'd4;

  localparam int MOD_NUM_BITS = 9;
  localparam int MOD_DEN_BITS = 8;
  localparam int MOD_CNT_BITS = $clog2(MOD_NUM_BITS + 1);
  localparam int OFFS_WIDTH   = 22;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            target;
    logic [OFFS_WIDTH-1:0] mem_offset;
    logic                  write_enable;
    logic [7:0]            write_byte;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [7:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [1:0]              target;
    logic [MOD_NUM_BITS-1:0] num;
    logic [MOD_DEN_BITS-1:0] den;
    logic [13:0]             low;
    logic [12:0]             ram_offset;
    logic                    write_enable;
    logic [7:0]              write_byte;
  } plan_t;

  typedef struct packed {
    logic                    busy;
    logic [MOD_DEN_BITS-1:0] rem;
  } mod_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

### design/cbm_mod_unit.sv
module cbm_mod_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [cbm_pkg::MOD_NUM_BITS-1:0] num,
  input  logic [cbm_pkg::MOD_DEN_BITS-1:0] den,
  output cbm_pkg::mod_res_t                res
);
  import cbm_pkg::*;

  logic [MOD_CNT_BITS-1:0] count;
  logic [MOD_NUM_BITS-1:0] num_sr;
  logic [MOD_DEN_BITS-1:0] rem;
  logic [MOD_DEN_BITS-1:0] den_q;
  logic [MOD_DEN_BITS:0]   trial;
  logic [MOD_DEN_BITS:0]   diff;
  logic                    fits;

  // one restoring step per cycle, msb first
  assign trial = {rem, num_sr[MOD_NUM_BITS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= MOD_CNT_BITS'(MOD_NUM_BITS);
    end else if (count != '0) begin
      count <= count - MOD_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= num;
      rem    <= '0;
      den_q  <= den;
    end else if (count != '0) begin
      num_sr <= {num_sr[MOD_NUM_BITS-2:0], 1'b0};
      rem    <= fits ? diff[MOD_DEN_BITS-1:0] : trial[MOD_DEN_BITS-1:0];
    end
  end

  assign res.busy = count != '0;
  assign res.rem  = rem;

endmodule

### design/cbm_bank_regs.sv
module cbm_bank_regs (
  input  logic                clk,
  input  logic                rst,
  input  cbm_pkg::cfg_write_t cfg,
  input  cbm_pkg::in_item_t   item,
  input  logic                commit,
  output cbm_pkg::plan_t      plan
);
  import cbm_pkg::*;

  logic [7:0] mapper_select;
  logic [7:0] prg_chunks;
  logic [7:0] chr_chunks;

  logic [4:0] serial_shift;
  logic [2:0] serial_count;
  logic [4:0] control_reg;
  logic [3:0] prg_bank_serial;
  logic [4:0] chr_bank_low;
  logic [4:0] chr_bank_high;
  logic [3:0] prg_bank_simple;
  logic [1:0] chr_bank_simple;
  logic [7:0] prg_bank_32k;

  logic [15:0] addr;
  logic [7:0]  data;
  logic [7:0]  prg_last;
  logic [4:0]  shift_next;
  logic        chr_window;

  assign addr       = item.bus_address;
  assign data       = item.bus_data;
  assign prg_last   = prg_chunks - 8'd1;
  assign shift_next = {data[0], serial_shift[4:1]};
  assign chr_window = addr[15:13] == 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_select <= '0;
      prg_chunks    <= 8'd2;
      chr_chunks    <= 8'd1;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_MAPPER:     mapper_select <= cfg.value;
        CFG_PRG_CHUNKS: prg_chunks    <= cfg.value;
        CFG_CHR_CHUNKS: chr_chunks    <= cfg.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_shift    <= '0;
      serial_count    <= '0;
      control_reg     <= CONTROL_RESET;
      prg_bank_serial <= '0;
      chr_bank_low    <= '0;
      chr_bank_high   <= '0;
      prg_bank_simple <= '0;
      chr_bank_simple <= '0;
      prg_bank_32k    <= '0;
    end else if (commit) begin
      if (item.req_type == REQ_REINIT) begin
        serial_shift    <= '0;
        serial_count    <= '0;
        control_reg     <= CONTROL_RESET;
        prg_bank_serial <= '0;
        chr_bank_low    <= '0;
        chr_bank_high   <= '0;
        prg_bank_simple <= '0;
        chr_bank_simple <= '0;
        prg_bank_32k    <= {1'b0, prg_chunks[7:1]} - 8'd1;
      end else if (item.req_type == REQ_PRG_WR) begin
        unique case (mapper_select)
          MAP_SERIAL: begin
            if (addr[15]) begin
              if (data[7]) begin
                serial_shift <= '0;
                serial_count <= '0;
                control_reg  <= control_reg | CONTROL_RESET;
              end else if (serial_count == SERIAL_LAST) begin
                serial_shift <= '0;
                serial_count <= '0;
                unique case (addr[14:13])
                  SER_CONTROL:  control_reg     <= shift_next;
                  SER_CHR_LOW:  chr_bank_low    <= shift_next;
                  SER_CHR_HIGH: chr_bank_high   <= shift_next;
                  SER_PRG_BANK: prg_bank_serial <= shift_next[3:0];
                  default: ;
                endcase
              end else begin
                serial_shift <= shift_next;
                serial_count <= serial_count + 3'd1;
              end
            end
          end
          MAP_PRG16: prg_bank_simple <= data[3:0];
          MAP_CHR8:  chr_bank_simple <= data[1:0];
          MAP_PRG32: prg_bank_32k    <= {5'd0, data[2:0]};
          default: ;
        endcase
      end
    end
  end

  // bank number above the window goes through the modulo unit
  always_comb begin
    plan = '0;
    plan.ram_offset = addr[12:0];
    priority if (item.req_type == REQ_PRG_RD) begin
      plan.den = prg_chunks;
      plan.low = addr[13:0];
      if (prg_chunks != 8'd0) begin
        plan.target = TGT_PRG_ROM;
      end
      unique case (mapper_select)
        MAP_SERIAL: begin
          if (!control_reg[3]) begin
            plan.num = {5'd0, prg_bank_serial[3:1], addr[14]};
          end else if (!addr[14]) begin
            plan.num = control_reg[2] ? {5'd0, prg_bank_serial} : '0;
          end else begin
            plan.num = control_reg[2] ? {1'b0, prg_last} : {5'd0, prg_bank_serial};
          end
        end
        MAP_PRG16: plan.num = addr[14] ? {1'b0, prg_last} : {5'd0, prg_bank_simple};
        MAP_PRG32: plan.num = {prg_bank_32k, addr[14]};
        default:   plan.num = (prg_chunks <= 8'd1) ? '0 : {8'd0, addr[14]};
      endcase
    end else if (item.req_type == REQ_CHR_RD || item.req_type == REQ_CHR_WR) begin
      plan.den = chr_chunks;
      plan.low = {1'b0, addr[12:0]};
      if (chr_window) begin
        if (chr_chunks == 8'd0) begin
          plan.target = TGT_CHR_RAM;
          if (item.req_type == REQ_CHR_WR) begin
            plan.write_enable = 1'b1;
            plan.write_byte   = data;
          end
        end else if (item.req_type == REQ_CHR_RD) begin
          plan.target = TGT_CHR_ROM;
        end
      end
      unique case (mapper_select)
        MAP_SERIAL: begin
          if (!control_reg[4]) begin
            plan.num = {5'd0, chr_bank_low[4:1]};
          end else if (!addr[12]) begin
            plan.num = {5'd0, chr_bank_low[4:1]};
            plan.low = {1'b0, chr_bank_low[0], addr[11:0]};
          end else begin
            plan.num = {5'd0, chr_bank_high[4:1]};
            plan.low = {1'b0, chr_bank_high[0], addr[11:0]};
          end
        end
        MAP_CHR8: plan.num = {7'd0, chr_bank_simple};
        default:  plan.num = '0;
      endcase
    end else begin
      plan.den = 8'd1;
    end
  end

endmodule

### design/cartridge_bank_mapper.sv
// Cartridge bank mapper. Each bus word (program or pattern read/write, or a
// re-initialise) returns one result word naming the target memory and the
// translated byte offset, reduced modulo the fitted ROM size, plus the
// pattern-RAM write enable and byte. Program writes update the bank
// registers, including the five-write serial loader. An item passes from
// acceptance through a start step that starts the modulo, one single-bit
// step per numerator bit in the shared restoring remainder unit, a step to
// see the unit finish and a commit step. The block takes one item at a
// time: the next word is taken only in the idle step after the commit.
// A finished result waits in the output register while the next item is
// already accepted; if it is still waiting when the next item is ready to
// commit, that item holds in its commit step. Configuration is taken in any
// cycle and must be written only while idle.
module cartridge_bank_mapper #(
  parameter int OFFSET_BITS = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cbm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import cbm_pkg::*;

  localparam int MaskBits = (OFFSET_BITS < OFFS_WIDTH) ? OFFSET_BITS : OFFS_WIDTH;
  localparam logic [OFFS_WIDTH-1:0] OffsMask =
    OFFS_WIDTH'((64'd1 << MaskBits) - 64'd1);

  state_t     state;
  state_t     state_next;
  in_item_t   item;
  plan_t      plan;
  mod_res_t   mod_res;
  cfg_write_t cfg;
  logic       mod_start;
  logic       commit;
  logic       out_load;
  logic [OFFS_WIDTH-1:0] offs_raw;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.value = cfg_data;

  cbm_bank_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .commit (commit),
    .plan   (plan)
  );

  cbm_mod_unit u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .num   (plan.num),
    .den   (plan.den),
    .res   (mod_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_START;
      ST_START:  state_next = ST_RUN;
      ST_RUN:    if (!mod_res.busy) state_next = ST_FINISH;
      ST_FINISH: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mod_start = 1'b0;
    commit    = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_START: mod_start = 1'b1;
      ST_RUN: ;
      ST_FINISH: begin
        commit   = !out_valid || out_ready;
        out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  always_comb begin
    unique case (plan.target)
      TGT_PRG_ROM: offs_raw = {mod_res.rem, plan.low};
      TGT_CHR_ROM: offs_raw = {1'b0, mod_res.rem, plan.low[12:0]};
      TGT_CHR_RAM: offs_raw = {9'd0, plan.ram_offset};
      default:     offs_raw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.target       <= plan.target;
      out_data.mem_offset   <= offs_raw & OffsMask;
      out_data.write_enable <= plan.write_enable;
      out_data.write_byte   <= plan.write_byte;
    end
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result word appeared outside the finish step");

  a_we_only_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_enable |-> out_data.target == TGT_CHR_RAM)
    else $error("write enable without pattern RAM target");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.target == TGT_NONE |->
      out_data.mem_offset == '0 && out_data.write_byte == '0)
    else $error("target none carries a nonzero offset or byte");

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mod_res.busy)
    else $error("modulo unit busy while idle");

endmodule

### bench/tb_cartridge_bank_mapper.sv
module tb_cartridge_bank_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  localparam int NPH = 16;
  localparam int PHASE_WORDS = 130;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AT_WORD = 700;

  localparam logic [7:0] PH_MAPPER [NPH] = '{
    MAP_SERIAL, MAP_SERIAL, MAP_SERIAL, MAP_PRG16, MAP_PRG16, MAP_CHR8, MAP_CHR8,
    MAP_PRG32, MAP_PRG32, 8'd0, 8'd255, MAP_SERIAL, 8'd5, MAP_PRG32, MAP_PRG16,
    MAP_SERIAL};
  localparam logic [7:0] PH_PRG [NPH] = '{
    8'd4, 8'd16, 8'd255, 8'd8, 8'd1, 8'd2, 8'd1, 8'd16, 8'd255, 8'd1, 8'd0, 8'd0,
    8'd2, 8'd3, 8'd255, 8'd3};
  localparam logic [7:0] PH_CHR [NPH] = '{
    8'd2, 8'd0, 8'd255, 8'd0, 8'd4, 8'd4, 8'd1, 8'd0, 8'd3, 8'd1, 8'd0, 8'd2,
    8'd2, 8'd7, 8'd255, 8'd5};

  class mapping_scoreboard;
    logic [7:0] mapper, prg_chunks, chr_chunks;
    logic [4:0] shift_acc;
    logic [2:0] shift_cnt;
    logic [4:0] control;
    logic [3:0] prg_bank_ser;
    logic [4:0] chr_lo, chr_hi;
    logic [3:0] prg_bank_16;
    logic [1:0] chr_bank_8;
    logic [7:0] prg_bank_32;
    logic       screen_page;
    out_item_t  translation_q[$];
    int         errors;
    int         checked;

    function new();
      mapper = 8'd0;
      prg_chunks = 8'd2;
      chr_chunks = 8'd1;
      errors = 0;
      checked = 0;
      clear_banks();
    endfunction

    function void clear_banks();
      int unsigned half;
      half = 32'(prg_chunks) / 2;
      shift_acc = '0;
      shift_cnt = '0;
      control = CONTROL_RESET;
      prg_bank_ser = '0;
      chr_lo = '0;
      chr_hi = '0;
      prg_bank_16 = '0;
      chr_bank_8 = '0;
      prg_bank_32 = 8'(half - 1);
      screen_page = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_MAPPER:     mapper = val;
        CFG_PRG_CHUNKS: prg_chunks = val;
        CFG_CHR_CHUNKS: chr_chunks = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return translation_q.size();
    endfunction

    // works out the target and offset of one accepted bus word and tracks its bank-register writes
    function void note_access(in_item_t it);
      int unsigned a, sz, low14, last, idx, mode;
      out_item_t r;
      a = 32'(it.bus_address);
      r = '0;
      idx = 0;
      case (it.req_type)
        REQ_PRG_RD: begin
          if (prg_chunks != 8'd0) begin
            sz = 32'(prg_chunks) * 16384;
            low14 = a & 32'h3FFF;
            last = 32'(prg_chunks) - 1;
            a = a & 32'h7FFF;
            if (mapper == MAP_SERIAL) begin
              mode = 32'(control[3:2]);
              if (mode <= 1)
                idx = a | (32'(prg_bank_ser & 4'hE) << 14);
              else if (a < 32'h4000)
                idx = (mode == 2) ? a : (low14 | (32'(prg_bank_ser) << 14));
              else
                idx = low14 | (((mode == 3) ? last : 32'(prg_bank_ser)) << 14);
            end else if (mapper == MAP_PRG16) begin
              idx = ((a < 32'h4000) ? 32'(prg_bank_16) : last) * 32'h4000 + low14;
            end else if (mapper == MAP_PRG32) begin
              idx = 32'(prg_bank_32) * 32'h8000 + a;
            end else begin
              idx = (sz <= 16384) ? low14 : a;
            end
            r.target = TGT_PRG_ROM;
            r.mem_offset = OFFS_WIDTH'(idx % sz);
          end
        end
        REQ_PRG_WR: begin
          if (mapper == MAP_SERIAL) begin
            if (a >= 32'h8000) begin
              if (it.bus_data[7]) begin
                shift_acc = '0;
                shift_cnt = '0;
                control = control | CONTROL_RESET;
              end else begin
                shift_acc = {it.bus_data[0], shift_acc[4:1]};
                if (shift_cnt == SERIAL_LAST) begin
                  case (it.bus_address[14:13])
                    SER_CONTROL:  control = shift_acc;
                    SER_CHR_LOW:  chr_lo = shift_acc;
                    SER_CHR_HIGH: chr_hi = shift_acc;
                    SER_PRG_BANK: prg_bank_ser = shift_acc[3:0];
                  endcase
                  shift_acc = '0;
                  shift_cnt = '0;
                end else begin
                  shift_cnt = shift_cnt + 3'd1;
                end
              end
            end
          end else if (mapper == MAP_PRG16) begin
            prg_bank_16 = it.bus_data[3:0];
          end else if (mapper == MAP_CHR8) begin
            chr_bank_8 = it.bus_data[1:0];
          end else if (mapper == MAP_PRG32) begin
            prg_bank_32 = {5'd0, it.bus_data[2:0]};
            screen_page = it.bus_data[4];
          end
        end
        REQ_CHR_RD, REQ_CHR_WR: begin
          if (a < 32'h2000) begin
            if (chr_chunks == 8'd0) begin
              r.target = TGT_CHR_RAM;
              r.mem_offset = OFFS_WIDTH'(a);
              if (it.req_type == REQ_CHR_WR) begin
                r.write_enable = 1'b1;
                r.write_byte = it.bus_data;
              end
            end else if (it.req_type == REQ_CHR_RD) begin
              sz = 32'(chr_chunks) * 8192;
              if (mapper == MAP_SERIAL) begin
                if (!control[4])
                  idx = 32'(chr_lo & 5'h1E) * 32'h1000 + a;
                else if (a < 32'h1000)
                  idx = 32'(chr_lo) * 32'h1000 + a;
                else
                  idx = 32'(chr_hi) * 32'h1000 + (a & 32'hFFF);
              end else if (mapper == MAP_CHR8) begin
                idx = 32'(chr_bank_8) * 32'h2000 + a;
              end else begin
                idx = a;
              end
              r.target = TGT_CHR_ROM;
              r.mem_offset = OFFS_WIDTH'(idx % sz);
            end
          end
        end
        REQ_REINIT: clear_banks();
        default: ;
      endcase
      translation_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40)
        $display("mismatch at result word %0d: %s", checked, msg);
    endtask

    task check_translation(out_item_t got);
      out_item_t want;
      if (translation_q.size() == 0) begin
        report($sformatf("unexpected word target %0h offset %0h", got.target, got.mem_offset));
      end else begin
        want = translation_q.pop_front();
        if (got.target !== want.target)
          report($sformatf("target got %0h want %0h", got.target, want.target));
        if (got.mem_offset !== want.mem_offset)
          report($sformatf("offset got %0h want %0h", got.mem_offset, want.mem_offset));
        if (got.write_enable !== want.write_enable)
          report($sformatf("write enable got %0b want %0b", got.write_enable,
                           want.write_enable));
        if (got.write_byte !== want.write_byte)
          report($sformatf("write byte got %0h want %0h", got.write_byte, want.write_byte));
      end
      checked++;
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  mapping_scoreboard sb;
  int sent_words;

  cartridge_bank_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

  task automatic send_access(input logic [2:0] req, input logic [15:0] addr,
                             input logic [7:0] data);
    int gap;
    gap = ((sent_words / 100) % 4 == 1) ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{req_type: req, bus_address: addr, bus_data: data};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_access(in_data);
    sent_words++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // five serial writes, bit 0 first; the last address picks the register
  task automatic serial_load(input logic [1:0] region, input logic [4:0] val, input bit noisy);
    for (int i = 0; i < 5; i++) begin
      if (noisy && $urandom_range(0, 23) == 0)
        send_access(REQ_PRG_WR, {1'b1, 15'($urandom)}, 8'h80 | 8'($urandom));
      send_access(REQ_PRG_WR, (i == 4) ? {1'b1, region, 13'($urandom)} : {1'b1, 15'($urandom)},
                  {1'b0, 6'($urandom), val[i]});
    end
  endtask

  task automatic send_random_access();
    logic [2:0]  req;
    logic [15:0] addr;
    case ($urandom_range(0, 3))
      0:       req = REQ_CHR_RD;
      1:       req = REQ_CHR_WR;
      default: req = REQ_PRG_RD;
    endcase
    if (req == REQ_PRG_RD)
      addr = {1'($urandom_range(0, 3) != 0), 15'($urandom)};
    else
      addr = ($urandom_range(0, 7) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)};
    send_access(req, addr, 8'($urandom));
  endtask

  task automatic run_random(input int quota);
    int done, burst;
    done = 0;
    while (done < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if (sb.mapper == MAP_SERIAL) begin
            serial_load(2'($urandom), 5'($urandom), 1'b1);
            done += 5;
          end else begin
            send_access(REQ_PRG_WR, 16'($urandom), 8'($urandom));
            done++;
          end
        end
        8: begin
          send_access(3'($urandom), 16'($urandom), 8'($urandom));
          done++;
        end
        9: begin
          if ($urandom_range(0, 2) == 0)
            send_access(REQ_REINIT, 16'($urandom), 8'($urandom));
          else
            send_random_access();
          done++;
        end
        default: begin
          burst = $urandom_range(1, 4);
          repeat (burst) send_random_access();
          done += burst;
        end
      endcase
    end
  endtask

  // result side: random hold-offs, quiet stretches and one long stall
  initial begin
    int gap, got;
    got = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ((got / 128) % 3 == 2) ? 0 : $urandom_range(0, 18);
      if (got == HOLD_AT_WORD)
        gap = LONG_HOLD;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_translation(out_data);
      got++;
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    sent_words = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // plain mapping at reset values
    send_access(REQ_PRG_RD, 16'h0000, 8'h00);
    send_access(REQ_PRG_RD, 16'hFFFF, 8'hFF);
    send_access(REQ_PRG_RD, 16'h7FFF, 8'h00);
    send_access(REQ_CHR_RD, 16'h0000, 8'h00);
    send_access(REQ_CHR_RD, 16'h1FFF, 8'h00);
    send_access(REQ_CHR_RD, 16'h2000, 8'h00);
    send_access(REQ_CHR_RD, 16'hFFFF, 8'hFF);
    send_access(REQ_CHR_WR, 16'h0123, 8'hA5);
    send_access(REQ_PRG_WR, 16'hFFFF, 8'hFF);
    send_access(REQ_REINIT, 16'h0000, 8'h00);
    send_access(3'd5, 16'hAAAA, 8'h55);
    send_access(3'd6, 16'h5555, 8'hAA);
    send_access(3'd7, 16'hFFFF, 8'hFF);
    drain();

    for (int p = 0; p < NPH; p++) begin
      write_reg(CFG_MAPPER, PH_MAPPER[p]);
      write_reg(CFG_PRG_CHUNKS, PH_PRG[p]);
      write_reg(CFG_CHR_CHUNKS, PH_CHR[p]);
      if (p == 0) begin
        send_access(REQ_PRG_WR, 16'h7FFF, 8'h01);
        send_access(REQ_PRG_WR, 16'h8000, 8'h80);
        serial_load(SER_CONTROL, 5'h1F, 1'b0);
        serial_load(SER_CHR_HIGH, 5'h03, 1'b0);
        send_access(REQ_CHR_RD, 16'h0FFF, 8'h00);
        send_access(REQ_CHR_RD, 16'h1000, 8'h00);
        send_access(REQ_PRG_RD, 16'hC000, 8'h00);
      end
      if ($urandom_range(0, 1) == 1)
        send_access(REQ_REINIT, 16'h0000, 8'h00);
      run_random(PHASE_WORDS);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
